>>> rtl/bmc_pkg.sv
package bmc_pkg;

  localparam int TICK_COUNT_BITS_DEF = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int HOLD_W = 16;
  localparam int PRESS_W = 8;

  typedef enum logic [1:0] {
    MODE_SOFT = 2'd0,
    MODE_IDLE = 2'd1,
    MODE_RUN  = 2'd2,
    MODE_ERR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    EV_TICK    = 2'd0,
    EV_FAULT   = 2'd1,
    EV_RUN_REQ = 2'd2,
    EV_NONE    = 2'd3
  } event_t;

  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_HOLD   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RUN_HOLD    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ERR_WINDOW  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_CLEAR = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ERR_LAST    = 3'd4;

  localparam logic [HOLD_W-1:0]  IDLE_HOLD_RST   = 16'd200;
  localparam logic [HOLD_W-1:0]  RUN_HOLD_RST    = 16'd300;
  localparam logic [HOLD_W-1:0]  ERR_WINDOW_RST  = 16'd100;
  localparam logic [PRESS_W-1:0] PRESS_CLEAR_RST = 8'd3;

  typedef struct packed {
    logic [HOLD_W-1:0]  idle_hold_ticks;
    logic [HOLD_W-1:0]  run_hold_ticks;
    logic [HOLD_W-1:0]  error_window_ticks;
    logic [PRESS_W-1:0] presses_to_clear;
    logic               error_from_last_run;
  } cfg_t;

  typedef struct packed {
    logic [1:0] current_mode;
    logic       run_pending;
    logic       error_pending;
    logic       store_error_write;
    logic       store_error_value;
  } res_t;

endpackage

>>> rtl/bmc_in_if.sv
interface bmc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       left_pressed;

  modport source (output valid, output mode, output left_pressed, input ready);
  modport sink (input valid, input mode, input left_pressed, output ready);
endinterface

>>> rtl/bmc_out_if.sv
interface bmc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] current_mode;
  logic       run_pending;
  logic       error_pending;
  logic       store_error_write;
  logic       store_error_value;

  modport source (
    output valid, output current_mode, output run_pending, output error_pending,
    output store_error_write, output store_error_value, input ready
  );
  modport sink (
    input valid, input current_mode, input run_pending, input error_pending,
    input store_error_write, input store_error_value, output ready
  );
endinterface

>>> rtl/bmc_cfg.sv
module bmc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bmc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output bmc_pkg::cfg_t                    cfg
);
  import bmc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_hold_ticks     <= IDLE_HOLD_RST;
      cfg.run_hold_ticks      <= RUN_HOLD_RST;
      cfg.error_window_ticks  <= ERR_WINDOW_RST;
      cfg.presses_to_clear    <= PRESS_CLEAR_RST;
      cfg.error_from_last_run <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IDLE_HOLD:   cfg.idle_hold_ticks     <= cfg_data[HOLD_W-1:0];
        REG_RUN_HOLD:    cfg.run_hold_ticks      <= cfg_data[HOLD_W-1:0];
        REG_ERR_WINDOW:  cfg.error_window_ticks  <= cfg_data[HOLD_W-1:0];
        REG_PRESS_CLEAR: cfg.presses_to_clear    <= cfg_data[PRESS_W-1:0];
        REG_ERR_LAST:    cfg.error_from_last_run <= cfg_data[0];
        default: ;
      endcase
    end
  end
endmodule

>>> rtl/bmc_core.sv
module bmc_core #(
  parameter int TICK_COUNT_BITS = bmc_pkg::TICK_COUNT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [1:0]     ev,
  input  logic           pressed,
  input  bmc_pkg::cfg_t  cfg,
  output bmc_pkg::res_t  res
);
  import bmc_pkg::*;

  localparam int CW = (TICK_COUNT_BITS > HOLD_W) ? TICK_COUNT_BITS : HOLD_W;

  mode_t                      mode, mode_next;
  logic [TICK_COUNT_BITS-1:0] tick_count, tick_count_next, tick_inc;
  logic                       run_flag, run_flag_next;
  logic                       error_flag, error_flag_next;
  logic                       press_latch, press_latch_next;
  logic                       window_open, window_open_next;
  logic [PRESS_W-1:0]         press_count, press_count_next;

  logic                       run_ev, err_ev;
  logic [CW-1:0]              tick_w;
  logic                       idle_hit, run_hit, win_hit;
  logic                       store_write, store_value;

  assign tick_inc = (tick_count == {TICK_COUNT_BITS{1'b1}}) ? tick_count
                                                            : tick_count + 1'b1;
  assign tick_w   = CW'(tick_inc);
  assign idle_hit = tick_w >= CW'(cfg.idle_hold_ticks);
  assign run_hit  = tick_w >= CW'(cfg.run_hold_ticks);
  assign win_hit  = tick_w >= CW'(cfg.error_window_ticks);

  // Event handling: flag and counter updates before the mode settles.
  always_comb begin
    tick_count_next  = tick_count;
    run_ev           = run_flag;
    err_ev           = error_flag;
    press_latch_next = press_latch;
    window_open_next = window_open;
    press_count_next = press_count;
    case (event_t'(ev))
      EV_TICK: begin
        tick_count_next = tick_inc;
        case (mode)
          MODE_SOFT: tick_count_next = '0;
          MODE_IDLE: begin
            if (!pressed) begin
              if (idle_hit) run_ev = 1'b1;
              tick_count_next = '0;
            end
          end
          MODE_RUN: begin
            if (!pressed) begin
              if (run_hit) run_ev = 1'b0;
              tick_count_next = '0;
            end
          end
          default: begin
            if (pressed) begin
              if (!press_latch) begin
                press_latch_next = 1'b1;
                press_count_next = press_count + 1'b1;
              end
              window_open_next = 1'b1;
            end else begin
              press_latch_next = 1'b0;
              if (win_hit) begin
                window_open_next = 1'b0;
                if (press_count == cfg.presses_to_clear) err_ev = 1'b0;
                press_count_next = '0;
              end
              if (win_hit || !window_open) tick_count_next = '0;
            end
          end
        endcase
      end
      EV_FAULT:   err_ev = 1'b1;
      EV_RUN_REQ: if (mode == MODE_IDLE) run_ev = 1'b1;
      default: ;
    endcase
  end

  // Mode resolution: error wins, otherwise the run request picks run or idle.
  always_comb begin
    error_flag_next = err_ev | ((mode == MODE_SOFT) & cfg.error_from_last_run);
    run_flag_next   = run_ev;
    if (error_flag_next) begin
      mode_next = MODE_ERR;
      if (mode == MODE_IDLE || mode == MODE_RUN) run_flag_next = 1'b0;
    end else if (run_ev) begin
      mode_next = MODE_RUN;
    end else begin
      mode_next = MODE_IDLE;
    end
  end

  always_comb begin
    store_write = (mode_next == MODE_ERR) != (mode == MODE_ERR);
    store_value = store_write & (mode_next == MODE_ERR);
  end

  assign res.current_mode      = mode_next;
  assign res.run_pending       = run_flag_next;
  assign res.error_pending     = error_flag_next;
  assign res.store_error_write = store_write;
  assign res.store_error_value = store_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_SOFT;
      tick_count  <= '0;
      run_flag    <= 1'b0;
      error_flag  <= 1'b0;
      press_latch <= 1'b0;
      window_open <= 1'b0;
      press_count <= '0;
    end else if (step) begin
      mode        <= mode_next;
      tick_count  <= tick_count_next;
      run_flag    <= run_flag_next;
      error_flag  <= error_flag_next;
      press_latch <= press_latch_next;
      window_open <= window_open_next;
      press_count <= press_count_next;
    end
  end

  a_err_mode_flag: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_ERR |-> error_flag)
    else $error("error mode without error flag");

  a_run_mode_flag: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_RUN |-> run_flag)
    else $error("run mode without run flag");

  a_store_on_change: assert property (@(posedge clk) disable iff (rst)
    step && store_write |=> $past(mode) != mode)
    else $error("store write without a mode change");
endmodule

>>> rtl/button_mode_controller.sv
// A request accepted into the input register is processed when it advances into the
// result register, which waits while an untaken result is held; it is valid from then on.
// Throughput: one request per cycle while results are taken; the input register and
// the result register let a new request enter while a finished result waits to be taken.
// Reset is synchronous: mode softstart, all flags and counters cleared, registers at defaults.
module button_mode_controller #(
  parameter int TICK_COUNT_BITS = bmc_pkg::TICK_COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  bmc_in_if.sink                           in_req,
  bmc_out_if.source                        out_res,
  input  logic                             cfg_we,
  input  logic [bmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bmc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bmc_pkg::*;

  cfg_t       cfg;
  res_t       res_next, res;
  logic       in_vld;
  logic [1:0] in_ev;
  logic       in_pressed;
  logic       out_vld;
  logic       advance;

  assign advance      = in_vld && (!out_vld || out_res.ready);
  assign in_req.ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_req.valid && in_req.ready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      in_ev      <= in_req.mode;
      in_pressed <= in_req.left_pressed;
    end
  end

  bmc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bmc_core #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .ev      (in_ev),
    .pressed (in_pressed),
    .cfg     (cfg),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (out_res.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign out_res.valid             = out_vld;
  assign out_res.current_mode      = res.current_mode;
  assign out_res.run_pending       = res.run_pending;
  assign out_res.error_pending     = res.error_pending;
  assign out_res.store_error_write = res.store_error_write;
  assign out_res.store_error_value = res.store_error_value;
endmodule
